/* sv/odpf_pkg.sv */
package odpf_pkg;

  localparam int DEF_PAGES = 8;
  localparam int DEF_WIDTH = 128;
  localparam int DEF_CHUNK_BYTES = 64;

  localparam logic [7:0] ERR_LIMIT_RESET = 8'd16;
  localparam logic [7:0] ERR_COUNT_MAX = 8'd255;

  localparam logic [7:0] CMD_COL_ADDR = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;

  localparam logic [1:0] OP_LINE = 2'd0;
  localparam logic [1:0] OP_WINDOW = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;
  localparam logic [1:0] OP_OUTCOME = 2'd3;

  localparam logic [1:0] K_LINE = 2'd0;
  localparam logic [1:0] K_WINDOW = 2'd1;
  localparam logic [1:0] K_DATA = 2'd2;
  localparam logic [1:0] K_OUTCOME = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] page;
    logic [6:0] column;
    logic       store;
    logic [7:0] pixel;
    logic       line_last;
    logic       transfer_ok;
  } cmd_t;

endpackage

/* sv/odpf_front.sv */
module odpf_front #(
  parameter int PAGES = odpf_pkg::DEF_PAGES,
  parameter int WIDTH = odpf_pkg::DEF_WIDTH
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [2:0]        page,
  input  logic [6:0]        column,
  input  logic [7:0]        pixel_byte,
  input  logic              line_last,
  input  logic              transfer_ok,
  input  logic              clearing,
  output logic              push_valid,
  input  logic              push_ready,
  output odpf_pkg::cmd_t    push_cmd
);
  import odpf_pkg::*;

  logic page_ok;
  logic drop;

  assign page_ok = 32'(page) < PAGES;
  assign drop = (opcode == OP_LINE) && !page_ok;

  assign in_ready = !clearing && push_ready;
  assign push_valid = in_valid && !clearing && !drop;

  always_comb begin
    push_cmd = '0;
    case (opcode)
      OP_LINE:    push_cmd.kind = K_LINE;
      OP_WINDOW:  push_cmd.kind = K_WINDOW;
      OP_DATA:    push_cmd.kind = K_DATA;
      OP_OUTCOME: push_cmd.kind = K_OUTCOME;
      default:    push_cmd.kind = K_OUTCOME;
    endcase
    push_cmd.page = page;
    push_cmd.column = column;
    push_cmd.store = 32'(column) < WIDTH;
    push_cmd.pixel = pixel_byte;
    push_cmd.line_last = line_last;
    push_cmd.transfer_ok = transfer_ok;
  end

endmodule

/* sv/odpf_queue.sv */
module odpf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  odpf_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output odpf_pkg::cmd_t pop_cmd
);
  import odpf_pkg::*;

  cmd_t       entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = count != 2'd2;
  assign pop_valid = count != 2'd0;
  assign pop_cmd = entry[rptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* sv/odpf_back.sv */
module odpf_back #(
  parameter int PAGES = odpf_pkg::DEF_PAGES,
  parameter int WIDTH = odpf_pkg::DEF_WIDTH,
  parameter int CHUNK_BYTES = odpf_pkg::DEF_CHUNK_BYTES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [7:0]     cfg_data,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  odpf_pkg::cmd_t pop_cmd,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           data_phase,
  output logic           first_of_transfer,
  output logic           last_of_transfer
);
  import odpf_pkg::*;

  localparam int DEPTH = PAGES * WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int CHUNKS = (WIDTH + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int CW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int COLW = $clog2(WIDTH + CHUNK_BYTES);
  localparam int KW = $clog2(CHUNK_BYTES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LCMP = 3'd2;
  localparam logic [2:0] S_WIN = 3'd3;
  localparam logic [2:0] S_DFETCH = 3'd4;
  localparam logic [2:0] S_DATA = 3'd5;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WIN = 2'd1;
  localparam logic [1:0] PH_READY = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  localparam logic [2:0] WB_COL_CMD = 3'd0;
  localparam logic [2:0] WB_COL_FIRST = 3'd1;
  localparam logic [2:0] WB_COL_LAST = 3'd2;
  localparam logic [2:0] WB_PAGE_CMD = 3'd3;
  localparam logic [2:0] WB_PAGE_FIRST = 3'd4;
  localparam logic [2:0] WB_PAGE_LAST = 3'd5;

  logic [7:0]       frame [DEPTH];
  logic [7:0]       rdata;
  logic             rzero;

  logic [2:0]       state;
  logic [1:0]       phase;
  logic [PAGES-1:0] dirty_pages;
  logic [CW-1:0]    chunk_index;
  logic             display_present;
  logic [7:0]       error_count;
  logic [7:0]       error_limit;
  logic             line_differs;
  logic [2:0]       latched_page;
  cmd_t             cur;
  logic [2:0]       win_idx;
  logic [KW-1:0]    k;
  logic [COLW-1:0]  col;
  logic [AW-1:0]    clr_addr;

  logic             out_free;
  logic             k_last;
  logic [2:0]       low_page;
  logic [PAGES-1:0] latched_mask;
  logic [PAGES-1:0] line_mask;
  logic [COLW-1:0]  c0;
  logic [15:0]      c0w;
  logic [15:0]      c1w;
  logic [COLW-1:0]  rd_col;
  logic             rd_step;
  logic [AW-1:0]    pop_addr;
  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    data_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       err_inc;
  logic             differs;
  logic [7:0]       win_byte;

  assign pop_ready = state == S_IDLE;
  assign clearing = state == S_CLEAR;
  assign out_free = !out_valid || out_ready;
  assign k_last = k == KW'(CHUNK_BYTES - 1);

  assign c0 = COLW'(32'(chunk_index) * CHUNK_BYTES);
  assign c0w = 16'(32'(chunk_index) * CHUNK_BYTES);
  assign c1w = c0w + 16'(CHUNK_BYTES - 1);

  assign rd_step = (state == S_DATA) && out_free && !k_last;
  assign rd_col = (state == S_DFETCH) ? c0 : col;
  assign pop_addr = AW'(32'(pop_cmd.page) * WIDTH + 32'(pop_cmd.column));
  assign cur_addr = AW'(32'(cur.page) * WIDTH + 32'(cur.column));
  assign data_addr = AW'(32'(latched_page) * WIDTH + 32'(rd_col));

  assign err_inc = (error_count == ERR_COUNT_MAX) ? ERR_COUNT_MAX : error_count + 8'd1;
  assign differs = line_differs || (cur.store && (rdata != cur.pixel));

  always_comb begin
    low_page = 3'd0;
    for (int i = PAGES - 1; i >= 0; i--) begin
      if (dirty_pages[i]) begin
        low_page = 3'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PAGES; i++) begin
      latched_mask[i] = latched_page == 3'(i);
      line_mask[i] = cur.page == 3'(i);
    end
  end

  always_comb begin
    case (win_idx)
      WB_COL_CMD:    win_byte = CMD_COL_ADDR;
      WB_COL_FIRST:  win_byte = c0w[7:0];
      WB_COL_LAST:   win_byte = c1w[7:0];
      WB_PAGE_CMD:   win_byte = CMD_PAGE_ADDR;
      WB_PAGE_FIRST: win_byte = {5'd0, latched_page};
      WB_PAGE_LAST:  win_byte = {5'd0, latched_page};
      default:       win_byte = 8'd0;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 8'd0;
    mem_re = 1'b0;
    mem_raddr = data_addr;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_re = pop_valid && (pop_cmd.kind == K_LINE) && pop_cmd.store;
        mem_raddr = pop_addr;
      end
      S_LCMP: begin
        mem_we = cur.store;
        mem_waddr = cur_addr;
        mem_wdata = cur.pixel;
      end
      S_DFETCH: begin
        mem_re = 32'(rd_col) < WIDTH;
      end
      S_DATA: begin
        mem_re = rd_step && (32'(rd_col) < WIDTH);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= frame[mem_raddr];
    end
    if ((state == S_DFETCH) || rd_step) begin
      rzero <= !(32'(rd_col) < WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      phase <= PH_IDLE;
      dirty_pages <= '1;
      chunk_index <= '0;
      display_present <= 1'b1;
      error_count <= 8'd0;
      error_limit <= ERR_LIMIT_RESET;
      line_differs <= 1'b0;
      latched_page <= 3'd0;
      win_idx <= 3'd0;
      k <= '0;
      col <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        error_limit <= cfg_data;
      end
      if (((state == S_WIN) || (state == S_DATA)) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_valid) begin
            cur <= pop_cmd;
            case (pop_cmd.kind)
              K_LINE: begin
                state <= S_LCMP;
              end
              K_WINDOW: begin
                if (display_present && (phase == PH_IDLE) && (|dirty_pages)) begin
                  latched_page <= low_page;
                  phase <= PH_WIN;
                  win_idx <= WB_COL_CMD;
                  state <= S_WIN;
                end
              end
              K_DATA: begin
                if (display_present && (phase == PH_READY)) begin
                  phase <= PH_DATA;
                  state <= S_DFETCH;
                end
              end
              K_OUTCOME: begin
                if ((phase == PH_WIN) || (phase == PH_DATA)) begin
                  if (pop_cmd.transfer_ok) begin
                    error_count <= 8'd0;
                    if (phase == PH_WIN) begin
                      phase <= PH_READY;
                    end else begin
                      phase <= PH_IDLE;
                      if (chunk_index == CW'(CHUNKS - 1)) begin
                        chunk_index <= '0;
                        dirty_pages <= dirty_pages & ~latched_mask;
                      end else begin
                        chunk_index <= chunk_index + 1'b1;
                      end
                    end
                  end else begin
                    error_count <= err_inc;
                    if (err_inc >= error_limit) begin
                      display_present <= 1'b0;
                    end
                    phase <= PH_IDLE;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_LCMP: begin
          if (cur.line_last) begin
            if (differs) begin
              dirty_pages <= dirty_pages | line_mask;
            end
            line_differs <= 1'b0;
          end else begin
            line_differs <= differs;
          end
          state <= S_IDLE;
        end
        S_WIN: begin
          if (out_free) begin
            out_byte <= win_byte;
            data_phase <= 1'b0;
            first_of_transfer <= win_idx == WB_COL_CMD;
            last_of_transfer <= win_idx == WB_PAGE_LAST;
            if (win_idx == WB_PAGE_LAST) begin
              state <= S_IDLE;
            end else begin
              win_idx <= win_idx + 3'd1;
            end
          end
        end
        S_DFETCH: begin
          col <= c0 + 1'b1;
          k <= '0;
          state <= S_DATA;
        end
        S_DATA: begin
          if (out_free) begin
            out_byte <= rzero ? 8'd0 : rdata;
            data_phase <= 1'b1;
            first_of_transfer <= k == '0;
            last_of_transfer <= k_last;
            if (k_last) begin
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
              col <= col + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_win_phase: assert property (@(posedge clk) disable iff (rst)
    (state == S_WIN) |-> (phase == PH_WIN))
    else $error("Window bytes are sent outside the window phase.");

  a_data_phase: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DFETCH) || (state == S_DATA)) |-> (phase == PH_DATA && display_present))
    else $error("Frame bytes are sent outside the data phase.");

  a_absent_idle: assert property (@(posedge clk) disable iff (rst)
    $fell(display_present) |-> (phase == PH_IDLE))
    else $error("Display dropped while a transfer was still pending.");

  a_chunk_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA && out_free && k_last) |=>
      (out_valid && last_of_transfer && data_phase && state == S_IDLE))
    else $error("Chunk did not end with a final data byte.");

endmodule

/* sv/oled_dirty_page_flush.sv */
// Display frame store with per-page dirty tracking and a chunked flush.
// Input items arrive on in_valid/in_ready and are accepted when both are high.
// A line byte write updates the store and marks its page dirty on the line's
// last byte if any byte changed. A window request emits six command bytes for
// the lowest dirty page, a data request emits CHUNK_BYTES frame bytes, and a
// transfer outcome advances the flush or counts failures against error_limit.
// Result bytes leave on out_valid/out_ready with their phase and framing flags.
// A two-entry queue sits between the decoder and the execution unit, so input
// items keep being taken while the output is stalled, until the queue fills.
// Line byte writes pass through the execution unit as a store read when the
// item is popped, then a compare and write back in S_LCMP; outcomes complete
// when popped. Window bytes and frame bytes are emitted at one byte per cycle
// when the receiver is ready, and the first frame byte is fetched in S_DFETCH.
// After reset the store is cleared one byte per cycle, all PAGES*WIDTH bytes
// (1024 by default), during which in_ready stays low; cfg_write is taken
// at any time. A stalled receiver holds the current byte and stops the flow.
module oled_dirty_page_flush #(
  parameter int PAGES = odpf_pkg::DEF_PAGES,
  parameter int WIDTH = odpf_pkg::DEF_WIDTH,
  parameter int CHUNK_BYTES = odpf_pkg::DEF_CHUNK_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [2:0] page,
  input  logic [6:0] column,
  input  logic [7:0] pixel_byte,
  input  logic       line_last,
  input  logic       transfer_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       data_phase,
  output logic       first_of_transfer,
  output logic       last_of_transfer
);
  import odpf_pkg::*;

  logic clearing;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  odpf_front #(
    .PAGES(PAGES),
    .WIDTH(WIDTH)
  ) u_front (
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .page(page),
    .column(column),
    .pixel_byte(pixel_byte),
    .line_last(line_last),
    .transfer_ok(transfer_ok),
    .clearing(clearing),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd(push_cmd)
  );

  odpf_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd(push_cmd),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_cmd(pop_cmd)
  );

  odpf_back #(
    .PAGES(PAGES),
    .WIDTH(WIDTH),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_cmd(pop_cmd),
    .clearing(clearing),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .data_phase(data_phase),
    .first_of_transfer(first_of_transfer),
    .last_of_transfer(last_of_transfer)
  );

endmodule
